// ===== hw/rtl/sinm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequence-number info map package
// Shared sizes, codes, cell control type and serial-order compare.
// ----------------------------------------------------------------------------
`default_nettype none

package sinm_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned INFO_BITS = 32;
  localparam int unsigned SEQ_BITS  = 16;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  localparam logic [SEQ_BITS-1:0] SEQ_HALF = {1'b1, {(SEQ_BITS-1){1'b0}}};

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } sinm_op_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_DROP   = 4'b0100,
    ST_APPEND = 4'b1000
  } sinm_state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } sinm_cell_ctrl_t;

  // a ahead of b in wrapping serial order
  function automatic logic seq_ahead(input logic [SEQ_BITS-1:0] a,
                                     input logic [SEQ_BITS-1:0] b);
    logic [SEQ_BITS-1:0] d;
    d = a - b;
    if (d == '0) begin
      return 1'b0;
    end else if (d == SEQ_HALF) begin
      return a > b;
    end else begin
      return d < SEQ_HALF;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sinm_if.sv =====
// ----------------------------------------------------------------------------
// Sequence-number info map channels
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sinm_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [sinm_pkg::SEQ_BITS-1:0]  seq_number;
  logic [sinm_pkg::INFO_BITS-1:0] info_value;

  modport source (output valid, output operation, output seq_number,
                  output info_value, input ready);
  modport sink   (input valid, input operation, input seq_number,
                  input info_value, output ready);
endinterface

interface sinm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [sinm_pkg::INFO_BITS-1:0] info_out;

  modport source (output valid, output found, output info_out, input ready);
  modport sink   (input valid, input found, input info_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sinm_cell.sv =====
// ----------------------------------------------------------------------------
// Sequence-number info map cell
// Holds one entry; loads a new pair or takes its younger neighbour's entry,
// and takes part in the first-match chain of a lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sinm_cell (
  input  wire                                  clk_i,
  input  sinm_pkg::sinm_cell_ctrl_t            ctrl_i,
  input  wire                                  live_i,
  input  wire  [sinm_pkg::SEQ_BITS-1:0]        key_i,
  input  wire  [sinm_pkg::INFO_BITS-1:0]       new_info_i,
  input  wire  [sinm_pkg::SEQ_BITS-1:0]        nbr_seq_i,
  input  wire  [sinm_pkg::INFO_BITS-1:0]       nbr_info_i,
  input  wire                                  hit_prev_i,
  output logic [sinm_pkg::SEQ_BITS-1:0]        seq_o,
  output logic [sinm_pkg::INFO_BITS-1:0]       info_o,
  output logic                                 hit_o,
  output logic [sinm_pkg::INFO_BITS-1:0]       sel_info_o
);

  logic [sinm_pkg::SEQ_BITS-1:0]  seq_q;
  logic [sinm_pkg::INFO_BITS-1:0] info_q;
  logic                           hit;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      seq_q  <= key_i;
      info_q <= new_info_i;
    end else if (ctrl_i.shift) begin
      seq_q  <= nbr_seq_i;
      info_q <= nbr_info_i;
    end
  end

  assign hit        = live_i && (seq_q == key_i);
  assign hit_o      = hit_prev_i | hit;
  assign sel_info_o = (hit && !hit_prev_i) ? info_q : '0;
  assign seq_o      = seq_q;
  assign info_o     = info_q;

endmodule

`default_nettype wire

// ===== hw/rtl/seq_number_info_map_core.sv =====
// ----------------------------------------------------------------------------
// Sequence-number info map
// Ordered window of wrapping sequence numbers with an info word each, held
// in a row of cells from oldest (cell 0) to newest.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries operation, seq_number and info_value. An insert gives no
//   response; a lookup gives one response on rsp_o (found, info_out, with
//   info_out zero when nothing matches).
//   A request transfers only while the controller is idle. A lookup is
//   accepted, then searches all cells at once and registers the response.
//   An insert is accepted, then drops the oldest entry while the new
//   number is not ahead of it, comparing at cell 0 and shifting the window
//   one cell towards the oldest end per dropped entry, and then appends.
//   A full window drops its oldest entry while appending, at no extra cost.
//   The response sits in an output register; inserts are still accepted
//   while it waits. A lookup held behind a stalled response waits in the
//   search step until the register frees.
//   Reset empties the window at once; cell contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_number_info_map_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  sinm_req_if.sink    req_i,
  sinm_rsp_if.source  rsp_o
);

  localparam int unsigned DEPTH = sinm_pkg::DEPTH;

  sinm_pkg::sinm_state_e               state_q, state_d;
  logic [sinm_pkg::CNT_W-1:0]          count_q, count_d;
  logic [sinm_pkg::SEQ_BITS-1:0]       key_q;
  logic [sinm_pkg::INFO_BITS-1:0]      new_info_q;
  logic                                out_valid_q, out_valid_d;
  logic                                found_q;
  logic [sinm_pkg::INFO_BITS-1:0]      out_info_q;

  logic [sinm_pkg::SEQ_BITS-1:0]       cell_seq  [DEPTH];
  logic [sinm_pkg::INFO_BITS-1:0]      cell_info [DEPTH];
  logic [sinm_pkg::INFO_BITS-1:0]      cell_sel  [DEPTH];
  logic [DEPTH:0]                      hit_chain;
  logic [DEPTH-1:0]                    load_vec;
  sinm_pkg::sinm_cell_ctrl_t           cell_ctrl [DEPTH];

  logic                                accept;
  logic                                drop;
  logic                                full;
  logic                                shift;
  logic                                out_load;
  logic [sinm_pkg::INFO_BITS-1:0]      lookup_info;

  assign accept    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == sinm_pkg::ST_IDLE);
  assign full      = (count_q == sinm_pkg::CNT_W'(DEPTH));
  assign drop      = (state_q == sinm_pkg::ST_DROP) && (count_q != '0) &&
                     !sinm_pkg::seq_ahead(key_q, cell_seq[0]);
  assign shift     = drop || ((state_q == sinm_pkg::ST_APPEND) && full);
  assign out_load  = (state_q == sinm_pkg::ST_LOOKUP) &&
                     (!out_valid_q || rsp_o.ready);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      load_vec[i] = 1'b0;
      if (state_q == sinm_pkg::ST_APPEND) begin
        if (full) begin
          load_vec[i] = (i == DEPTH - 1);
        end else begin
          load_vec[i] = (count_q[sinm_pkg::IDX_W-1:0] == sinm_pkg::IDX_W'(i));
        end
      end
      cell_ctrl[i].shift = shift;
      cell_ctrl[i].load  = load_vec[i];
    end
  end

  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [sinm_pkg::SEQ_BITS-1:0]  nbr_seq;
    logic [sinm_pkg::INFO_BITS-1:0] nbr_info;
    logic                           live;

    if (g == DEPTH - 1) begin : g_last
      assign nbr_seq  = '0;
      assign nbr_info = '0;
    end else begin : g_mid
      assign nbr_seq  = cell_seq[g+1];
      assign nbr_info = cell_info[g+1];
    end

    assign live = (sinm_pkg::CNT_W'(g) < count_q);

    sinm_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[g]),
      .live_i     (live),
      .key_i      (key_q),
      .new_info_i (new_info_q),
      .nbr_seq_i  (nbr_seq),
      .nbr_info_i (nbr_info),
      .hit_prev_i (hit_chain[g]),
      .seq_o      (cell_seq[g]),
      .info_o     (cell_info[g]),
      .hit_o      (hit_chain[g+1]),
      .sel_info_o (cell_sel[g])
    );
  end

  always_comb begin
    lookup_info = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lookup_info = lookup_info | cell_sel[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      sinm_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.operation == sinm_pkg::OP_LOOKUP) ?
                    sinm_pkg::ST_LOOKUP : sinm_pkg::ST_DROP;
        end
      end
      sinm_pkg::ST_LOOKUP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = sinm_pkg::ST_IDLE;
        end
      end
      sinm_pkg::ST_DROP: begin
        if (drop) begin
          count_d = count_q - sinm_pkg::CNT_W'(1);
        end else begin
          state_d = sinm_pkg::ST_APPEND;
        end
      end
      sinm_pkg::ST_APPEND: begin
        if (!full) begin
          count_d = count_q + sinm_pkg::CNT_W'(1);
        end
        state_d = sinm_pkg::ST_IDLE;
      end
      default: begin
        state_d = sinm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sinm_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q      <= req_i.seq_number;
      new_info_q <= req_i.info_value;
    end
    if (out_load) begin
      found_q    <= hit_chain[DEPTH];
      out_info_q <= lookup_info;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.found    = found_q;
  assign rsp_o.info_out = out_info_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sinm_pkg::CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |=> (count_q == $past(count_q) - sinm_pkg::CNT_W'(1)))
    else $error("drop did not shrink window");

  a_lookup_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.operation == sinm_pkg::OP_LOOKUP))
      |=> (state_q == sinm_pkg::ST_LOOKUP))
    else $error("lookup did not enter search step");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sinm_pkg::ST_LOOKUP))
    else $error("response without lookup");

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(load_vec))
    else $error("more than one cell loaded");
`endif

endmodule

`default_nettype wire

// ===== tb/seq_number_info_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence-number info map checker
// Watches both channels. Keeps its own copy of the window, works out the
// answer to every accepted lookup, and compares each response transfer with
// the oldest answer still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_number_info_map_checker (
  input  wire   clk_i,
  input  wire   rst_ni,
  sinm_req_if   req_i,
  sinm_rsp_if   rsp_i,
  output int    fail_count_o,
  output int    pending_o
);
  import sinm_pkg::*;

  typedef struct packed {
    logic [SEQ_BITS-1:0]  seq;
    logic                 found;
    logic [INFO_BITS-1:0] info;
  } lookup_answer_t;

  logic [SEQ_BITS-1:0]  win_seq  [DEPTH];
  logic [INFO_BITS-1:0] win_info [DEPTH];
  int unsigned          win_head;
  int unsigned          win_count;
  lookup_answer_t       answers_q [$];
  int                   fail_count;

  function automatic logic leads(input logic [SEQ_BITS-1:0] a,
                                 input logic [SEQ_BITS-1:0] b);
    logic [SEQ_BITS-1:0] d;
    d = a - b;
    if (d == '0) return 1'b0;
    if (d == SEQ_HALF) return a > b;
    return !d[SEQ_BITS-1];
  endfunction

  task automatic drop_oldest();
    win_head  = (win_head + 1) % DEPTH;
    win_count = win_count - 1;
  endtask

  task automatic insert_entry(input logic [SEQ_BITS-1:0] seq,
                              input logic [INFO_BITS-1:0] info);
    int unsigned slot;
    while (win_count > 0 && !leads(seq, win_seq[win_head])) drop_oldest();
    if (win_count >= DEPTH) drop_oldest();
    slot           = (win_head + win_count) % DEPTH;
    win_seq[slot]  = seq;
    win_info[slot] = info;
    win_count      = win_count + 1;
  endtask

  function automatic lookup_answer_t search(input logic [SEQ_BITS-1:0] seq);
    lookup_answer_t ans;
    int unsigned    slot;
    ans = '{seq: seq, found: 1'b0, info: '0};
    for (int unsigned i = 0; i < win_count; i++) begin
      slot = (win_head + i) % DEPTH;
      if (win_seq[slot] == seq) begin
        ans.found = 1'b1;
        ans.info  = win_info[slot];
        break;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_answer_t want;
    if (!rst_ni) begin
      win_head   = 0;
      win_count  = 0;
      fail_count = 0;
      answers_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // check responses first: an answer queued at this edge is not yet due
      if (rsp_i.valid && rsp_i.ready) begin
        if (answers_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response: found=%0b info=%h",
                     rsp_i.found, rsp_i.info_out);
        end else begin
          want = answers_q.pop_front();
          if (rsp_i.found !== want.found || rsp_i.info_out !== want.info) begin
            fail_count++;
            if (fail_count <= 10)
              $display("lookup %h: expected found=%0b info=%h, got found=%0b info=%h",
                       want.seq, want.found, want.info, rsp_i.found, rsp_i.info_out);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.operation == OP_LOOKUP) answers_q.push_back(search(req_i.seq_number));
        else insert_entry(req_i.seq_number, req_i.info_value);
      end
      fail_count_o <= fail_count;
      pending_o    <= answers_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/seq_number_info_map_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence-number info map testbench
// Drives inserts and lookups with random gaps and response stalls: a short
// directed run over wrap-around, half-range order, wiping and full-window
// cases, then mostly rising sequence streams with random content and noise.
// A checker beside the block predicts and compares every lookup response.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_number_info_map_core_tb;
  import sinm_pkg::*;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic steady = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  sinm_req_if req_ch ();
  sinm_rsp_if rsp_ch ();

  seq_number_info_map_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  seq_number_info_map_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
        rsp_ch.ready <= 1'b0;
        stall_left = idle_len();
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("seq_number_info_map_core_tb failed");
        $finish;
      end
    end
  end

  task automatic send_req(input sinm_op_e op, input logic [SEQ_BITS-1:0] seq,
                          input logic [INFO_BITS-1:0] info);
    int gap;
    gap = steady ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.seq_number <= seq;
    req_ch.info_value <= info;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    logic [SEQ_BITS-1:0] last_seq;
    logic [SEQ_BITS-1:0] key;
    logic [SEQ_BITS-1:0] recent_q [$];
    int                  r;
    int                  s;

    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_INSERT;
    req_ch.seq_number <= '0;
    req_ch.info_value <= '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_req(OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 16'h0000, 32'h0000_0000);
    send_req(OP_LOOKUP, 16'hFFFF, 32'h0);
    send_req(OP_INSERT, 16'h8000, 32'hA5A5_5A5A);
    send_req(OP_LOOKUP, 16'hFFFF, 32'h0);
    send_req(OP_LOOKUP, 16'h0000, 32'h0);
    send_req(OP_INSERT, 16'h0000, 32'h1234_5678);
    for (int i = 1; i <= 16; i++)
      send_req(OP_INSERT, SEQ_BITS'(i), {16'(i), ~16'(i)});
    send_req(OP_LOOKUP, 16'h0000, 32'h0);
    send_req(OP_LOOKUP, 16'h0010, 32'h0);
    hold_until_drained();

    last_seq = $urandom_range(0, 65535);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) steady = ((n / 150) % 3 == 1);
      if (n % 250 == 0) begin
        last_seq = (n % 500 == 0) ? 16'hFFF0 - 16'($urandom_range(0, 20))
                                  : 16'($urandom_range(0, 65535));
        recent_q.delete();
      end
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < 50) begin
        if (s < 80)      last_seq = last_seq + 16'($urandom_range(1, 4));
        else if (s < 90) last_seq = last_seq - 16'($urandom_range(0, 20));
        else if (s < 95) last_seq = last_seq ^ SEQ_HALF;
        else             last_seq = 16'($urandom_range(0, 65535));
        recent_q.push_back(last_seq);
        if (recent_q.size() > 24) void'(recent_q.pop_front());
        send_req(OP_INSERT, last_seq, $urandom);
      end else begin
        if (s < 65 && recent_q.size() > 0)
          key = recent_q[$urandom_range(0, recent_q.size() - 1)];
        else if (s < 85)
          key = last_seq + 16'($urandom_range(1, 3));
        else
          key = 16'($urandom_range(0, 65535));
        send_req(OP_LOOKUP, key, $urandom);
      end
    end
    steady = 1'b0;

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("seq_number_info_map_core_tb passed");
    end else begin
      $display("seq_number_info_map_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
